// ===== rtl/calendar_date_arithmetic_unit_defines.svh =====
// Assertion macros for the checker file of the date arithmetic unit.
`ifndef CALENDAR_DATE_ARITHMETIC_UNIT_DEFINES_SVH
`define CALENDAR_DATE_ARITHMETIC_UNIT_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define CDAU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Concurrent assertion that also holds across reset.
`define CDAU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cdau_pkg.sv =====
package cdau_pkg;

    // Width of the shared adder and of the wide work registers.
    localparam int DW = 26;
    // Internal year width: a year grows past 14 bits while months are added.
    localparam int YW = 15;

    // Stream widths.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    // Opcodes.
    localparam logic [2:0] OP_ADD_DAYS       = 3'd0;
    localparam logic [2:0] OP_ADD_MONTHS     = 3'd1;
    localparam logic [2:0] OP_DAY_DIFF       = 3'd2;
    localparam logic [2:0] OP_MONTHS_BETWEEN = 3'd3;
    localparam logic [2:0] OP_VALIDATE       = 3'd4;

    // Year chunk levels used while taking a year apart.
    localparam logic [1:0] LVL_400 = 2'd0;
    localparam logic [1:0] LVL_100 = 2'd1;
    localparam logic [1:0] LVL_4   = 2'd2;
    localparam logic [1:0] LVL_1   = 2'd3;

    localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [3:0] MONTH_CLAMP     = 4'd13;

    // The year is analyzed as y + 399, so y = 0 still gets a clean remainder.
    localparam logic [8:0] YEAR_BIAS = 9'd399;
    // Day count of the 400 year bias, taken off the running total up front.
    localparam logic [DW-1:0] TOT_BIAS = DW'(-146097);

    typedef struct packed {
        logic [2:0]  opcode;
        logic [4:0]  a_day;
        logic [3:0]  a_month;
        logic [13:0] a_year;
        logic [4:0]  b_day;
        logic [3:0]  b_month;
        logic [13:0] b_year;
        logic [15:0] amount;
    } cdau_item_t;

    typedef struct packed {
        logic [4:0]  r_day;
        logic [3:0]  r_month;
        logic [13:0] r_year;
        logic [22:0] count;
        logic        a_valid;
        logic        b_after_a;
        logic        error;
    } cdau_result_t;

    typedef struct packed {
        logic [DW-1:0] sum;
        logic          neg;
        logic          zero;
    } cdau_alu_t;

    // Length of a month; codes outside 1..12 read as 31.
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Years in one chunk of the given level.
    function automatic logic [8:0] year_chunk(input logic [1:0] lvl);
        logic [8:0] yrs;
        case (lvl)
            LVL_400: yrs = 9'd400;
            LVL_100: yrs = 9'd100;
            LVL_4:   yrs = 9'd4;
            default: yrs = 9'd1;
        endcase
        return yrs;
    endfunction

    // Days in one chunk of the given level.
    function automatic logic [17:0] chunk_days(input logic [1:0] lvl);
        logic [17:0] days;
        case (lvl)
            LVL_400: days = 18'd146097;
            LVL_100: days = 18'd36524;
            LVL_4:   days = 18'd1461;
            default: days = 18'd365;
        endcase
        return days;
    endfunction

    // Leap test from the mixed radix remainder of (year + 399) mod 400.
    function automatic logic leap_of(input logic [1:0] c100, input logic [4:0] c4,
                                     input logic [1:0] c1);
        return (c1 == 2'd3) && ((c4 != 5'd24) || (c100 == 2'd3));
    endfunction

    // Clamp a wide difference into the 23 bit signed result range.
    function automatic logic [22:0] sat_count(input logic [DW-1:0] v);
        logic [DW-23:0] hi;
        logic [22:0]    r;
        hi = v[DW-1:22];
        if ((hi == '0) || (hi == '1)) begin
            r = v[22:0];
        end else if (v[DW-1]) begin
            r = 23'h400000;
        end else begin
            r = 23'h3FFFFF;
        end
        return r;
    endfunction

endpackage

// ===== rtl/cdau_alu.sv =====
module cdau_alu import cdau_pkg::*; (
    input  logic [DW-1:0] op_a,
    input  logic [DW-1:0] op_b,
    input  logic          sub,
    output cdau_alu_t     res
);

    logic [DW-1:0] sum;

    // One adder serves both add and subtract: invert and carry in for subtract.
    always_comb begin
        sum      = op_a + (op_b ^ {DW{sub}}) + {{(DW-1){1'b0}}, sub};
        res.sum  = sum;
        res.neg  = sum[DW-1];
        res.zero = (sum == '0);
    end

endmodule

// ===== rtl/cdau_seq.sv =====
module cdau_seq import cdau_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  cdau_item_t   item,
    output logic         ready,
    output logic         res_valid,
    input  logic         res_ready,
    output cdau_result_t res
);

    typedef enum logic [17:0] {
        S_IDLE  = 18'b000000000000000001,
        S_YINIT = 18'b000000000000000010,
        S_YSUB  = 18'b000000000000000100,
        S_YADD  = 18'b000000000000001000,
        S_MSUM  = 18'b000000000000010000,
        S_MDAY  = 18'b000000000000100000,
        S_DIFF  = 18'b000000000001000000,
        S_DLOAD = 18'b000000000010000000,
        S_DSTEP = 18'b000000000100000000,
        S_MLOAD = 18'b000000001000000000,
        S_MSTEP = 18'b000000010000000000,
        S_KEY   = 18'b000000100000000000,
        S_CNT0  = 18'b000001000000000000,
        S_CNT1  = 18'b000010000000000000,
        S_CNT2  = 18'b000100000000000000,
        S_CNT3  = 18'b001000000000000000,
        S_CNT4  = 18'b010000000000000000,
        S_DONE  = 18'b100000000000000000
    } state_t;

    state_t        state_reg, state_next;
    cdau_item_t    item_reg, item_next;
    cdau_result_t  res_reg, res_next;
    logic [YW-1:0] y_reg, y_next;
    logic [YW-1:0] yrem_reg, yrem_next;
    logic [1:0]    lvl_reg, lvl_next;
    logic [1:0]    c100_reg, c100_next;
    logic [4:0]    c4_reg, c4_next;
    logic [1:0]    c1_reg, c1_next;
    logic [DW-1:0] tot_reg, tot_next;
    logic [DW-1:0] save_reg, save_next;
    logic [DW-1:0] work_reg, work_next;
    logic [3:0]    mon_reg, mon_next;
    logic          phase_reg, phase_next;

    logic [DW-1:0] alu_a, alu_b;
    logic          alu_sub;
    cdau_alu_t     alu;

    logic          leap;
    logic [4:0]    cur_len;
    logic [4:0]    a_len;
    logic [3:0]    cur_m;
    logic [4:0]    cur_d;
    logic [3:0]    top_m;
    logic [22:0]   key_a, key_b;

    cdau_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .sub  (alu_sub),
        .res  (alu)
    );

    // Calendar facts for the year currently held in the leap counters.
    always_comb begin
        leap    = leap_of(c100_reg, c4_reg, c1_reg);
        cur_len = days_in(mon_reg, leap);
        a_len   = days_in(item_reg.a_month, leap);
        cur_m   = phase_reg ? item_reg.b_month : item_reg.a_month;
        cur_d   = phase_reg ? item_reg.b_day : item_reg.a_day;
        top_m   = (cur_m > MONTH_CLAMP) ? MONTH_CLAMP : cur_m;
        key_a   = {item_reg.a_year, item_reg.a_month, item_reg.a_day};
        key_b   = {item_reg.b_year, item_reg.b_month, item_reg.b_day};
    end

    // Sequencer: picks the adder operands and updates the work registers.
    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        y_next     = y_reg;
        yrem_next  = yrem_reg;
        lvl_next   = lvl_reg;
        c100_next  = c100_reg;
        c4_next    = c4_reg;
        c1_next    = c1_reg;
        tot_next   = tot_reg;
        save_next  = save_reg;
        work_next  = work_reg;
        mon_next   = mon_reg;
        phase_next = phase_reg;
        alu_a      = '0;
        alu_b      = '0;
        alu_sub    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    item_next  = item;
                    res_next   = '0;
                    y_next     = YW'(item.a_year);
                    mon_next   = item.a_month;
                    phase_next = 1'b0;
                    unique case (item.opcode) inside
                        OP_ADD_DAYS, OP_ADD_MONTHS: begin
                            if ((item.a_month == 4'd0) || (item.a_month > MONTHS_PER_YEAR)) begin
                                res_next.error = 1'b1;
                                state_next     = S_DONE;
                            end else if (item.opcode == OP_ADD_DAYS) begin
                                state_next = S_YINIT;
                            end else begin
                                state_next = S_MLOAD;
                            end
                        end
                        OP_DAY_DIFF:                    state_next = S_YINIT;
                        OP_MONTHS_BETWEEN, OP_VALIDATE: state_next = S_KEY;
                        default:                        state_next = S_DONE;
                    endcase
                end
            end

            // Start a year analysis on y + 399.
            S_YINIT: begin
                alu_a      = DW'(y_reg);
                alu_b      = DW'(YEAR_BIAS);
                yrem_next  = alu.sum[YW-1:0];
                tot_next   = TOT_BIAS;
                lvl_next   = LVL_400;
                c100_next  = 2'd0;
                c4_next    = 5'd0;
                c1_next    = 2'd0;
                state_next = S_YSUB;
            end

            // Take one chunk of years off, or move down a level.
            S_YSUB: begin
                alu_a   = DW'(yrem_reg);
                alu_b   = DW'(year_chunk(lvl_reg));
                alu_sub = 1'b1;
                if (alu.neg) begin
                    if (lvl_reg != LVL_1) begin
                        lvl_next = lvl_reg + 2'd1;
                    end else begin
                        // Year analysis finished; continue per opcode.
                        case (item_reg.opcode)
                            OP_ADD_DAYS: state_next = S_DLOAD;
                            OP_ADD_MONTHS: begin
                                res_next.r_day   = (item_reg.a_day > cur_len) ?
                                                   cur_len : item_reg.a_day;
                                res_next.r_month = mon_reg;
                                res_next.r_year  = y_reg[13:0];
                                state_next       = S_DONE;
                            end
                            OP_DAY_DIFF: begin
                                mon_next = 4'd1;
                                if (y_reg == '0) begin
                                    tot_next = '0;
                                end
                                state_next = S_MSUM;
                            end
                            default: begin
                                res_next.a_valid = (item_reg.a_year > 14'd1) &&
                                    (item_reg.a_month != 4'd0) &&
                                    (item_reg.a_month <= MONTHS_PER_YEAR) &&
                                    (item_reg.a_day != 5'd0) &&
                                    (item_reg.a_day <= a_len);
                                state_next = S_DONE;
                            end
                        endcase
                    end
                end else begin
                    yrem_next = alu.sum[YW-1:0];
                    case (lvl_reg)
                        LVL_100: c100_next = c100_reg + 2'd1;
                        LVL_4:   c4_next   = c4_reg + 5'd1;
                        LVL_1:   c1_next   = c1_reg + 2'd1;
                        default: ;
                    endcase
                    state_next = S_YADD;
                end
            end

            // Add the days of the chunk just taken.
            S_YADD: begin
                alu_a      = tot_reg;
                alu_b      = DW'(chunk_days(lvl_reg));
                tot_next   = alu.sum;
                state_next = S_YSUB;
            end

            // Add whole months before the current month.
            S_MSUM: begin
                if (mon_reg < top_m) begin
                    alu_a    = tot_reg;
                    alu_b    = DW'(cur_len);
                    tot_next = alu.sum;
                    mon_next = mon_reg + 4'd1;
                end else begin
                    state_next = S_MDAY;
                end
            end

            // Add the day; the first date's number is set aside.
            S_MDAY: begin
                alu_a = tot_reg;
                alu_b = DW'(cur_d);
                if (!phase_reg) begin
                    save_next  = alu.sum;
                    phase_next = 1'b1;
                    y_next     = YW'(item_reg.b_year);
                    state_next = S_YINIT;
                end else begin
                    tot_next   = alu.sum;
                    state_next = S_DIFF;
                end
            end

            S_DIFF: begin
                alu_a          = tot_reg;
                alu_b          = save_reg;
                alu_sub        = 1'b1;
                res_next.count = sat_count(alu.sum);
                state_next     = S_DONE;
            end

            S_DLOAD: begin
                alu_a      = DW'(item_reg.a_day);
                alu_b      = DW'(item_reg.amount);
                work_next  = alu.sum;
                state_next = S_DSTEP;
            end

            // Walk one month forward while the day count overruns it.
            S_DSTEP: begin
                alu_a   = work_reg;
                alu_b   = DW'(cur_len);
                alu_sub = 1'b1;
                if (alu.neg || alu.zero) begin
                    res_next.r_day   = work_reg[4:0];
                    res_next.r_month = mon_reg;
                    res_next.r_year  = y_reg[13:0];
                    state_next       = S_DONE;
                end else begin
                    work_next = alu.sum;
                    if (mon_reg == MONTHS_PER_YEAR) begin
                        mon_next = 4'd1;
                        y_next   = y_reg + YW'(1);
                        if (c1_reg == 2'd3) begin
                            c1_next = 2'd0;
                            if (c4_reg == 5'd24) begin
                                c4_next   = 5'd0;
                                c100_next = c100_reg + 2'd1;
                            end else begin
                                c4_next = c4_reg + 5'd1;
                            end
                        end else begin
                            c1_next = c1_reg + 2'd1;
                        end
                    end else begin
                        mon_next = mon_reg + 4'd1;
                    end
                end
            end

            S_MLOAD: begin
                alu_a      = DW'(item_reg.amount);
                alu_b      = DW'(item_reg.a_month - 4'd1);
                work_next  = alu.sum;
                state_next = S_MSTEP;
            end

            // Split the month total into years and a month by repeated subtract.
            S_MSTEP: begin
                alu_a   = work_reg;
                alu_b   = DW'(MONTHS_PER_YEAR);
                alu_sub = 1'b1;
                if (alu.neg) begin
                    mon_next   = work_reg[3:0] + 4'd1;
                    state_next = S_YINIT;
                end else begin
                    work_next = alu.sum;
                    y_next    = y_reg + YW'(1);
                end
            end

            // Compare the packed dates: the sign tells whether a lies after b.
            S_KEY: begin
                alu_a   = DW'(key_b);
                alu_b   = DW'(key_a);
                alu_sub = 1'b1;
                if (item_reg.opcode == OP_MONTHS_BETWEEN) begin
                    if (alu.neg) begin
                        res_next.error = 1'b1;
                        res_next.count = '1;
                        state_next     = S_DONE;
                    end else begin
                        state_next = S_CNT0;
                    end
                end else begin
                    res_next.b_after_a = !alu.neg && !alu.zero;
                    state_next         = S_YINIT;
                end
            end

            S_CNT0: begin
                alu_a      = DW'(item_reg.b_year);
                alu_b      = DW'(item_reg.a_year);
                alu_sub    = 1'b1;
                work_next  = alu.sum;
                state_next = S_CNT1;
            end

            // Times twelve as eight plus four.
            S_CNT1: begin
                alu_a      = {work_reg[DW-4:0], 3'b000};
                alu_b      = {work_reg[DW-3:0], 2'b00};
                work_next  = alu.sum;
                state_next = S_CNT2;
            end

            S_CNT2: begin
                alu_a      = work_reg;
                alu_b      = DW'(item_reg.b_month);
                work_next  = alu.sum;
                state_next = S_CNT3;
            end

            S_CNT3: begin
                alu_a      = work_reg;
                alu_b      = DW'(item_reg.a_month);
                alu_sub    = 1'b1;
                work_next  = alu.sum;
                state_next = S_CNT4;
            end

            // A partial month at the end does not count.
            S_CNT4: begin
                alu_a          = work_reg;
                alu_b          = DW'(item_reg.b_day < item_reg.a_day);
                alu_sub        = 1'b1;
                res_next.count = alu.sum[22:0];
                state_next     = S_DONE;
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Work registers.
    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        res_reg   <= res_next;
        y_reg     <= y_next;
        yrem_reg  <= yrem_next;
        lvl_reg   <= lvl_next;
        c100_reg  <= c100_next;
        c4_reg    <= c4_next;
        c1_reg    <= c1_next;
        tot_reg   <= tot_next;
        save_reg  <= save_next;
        work_reg  <= work_next;
        mon_reg   <= mon_next;
        phase_reg <= phase_next;
    end

    assign ready     = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

// ===== rtl/calendar_date_arithmetic_unit.sv =====
// Channel  | Direction | Content
// ---------+-----------+-------------------------------------------------
// s_       | input     | one date request: opcode in tuser, dates and amount
// m_       | output    | one result: date, count, flags in tdata, error in tuser
//
// The shared adder does one step a cycle; year analysis works chunk by chunk,
// adding days takes one step per month and adding months one step per year.
// Reset is synchronous and active low; it clears the sequencer and the
// output valid. A finished result waits in the output register, so the next
// transaction is accepted while it stalls; s_tready is high only when idle.
module calendar_date_arithmetic_unit import cdau_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // a_day, a_month, a_year, b_day, b_month, b_year, amount, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode
    input  logic [2:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // r_day, r_month, r_year, count, a_valid, b_after_a
    output logic [M_TDATA_W-1:0] m_tdata,
    // error
    output logic [0:0]           m_tuser
);

    cdau_item_t   item;
    cdau_result_t res;
    cdau_result_t out_reg;
    logic         out_valid_reg;
    logic         core_ready;
    logic         res_valid;
    logic         res_ready;

    // Unpack the input transaction.
    always_comb begin
        item.opcode  = s_tuser;
        item.a_day   = s_tdata[4:0];
        item.a_month = s_tdata[8:5];
        item.a_year  = s_tdata[22:9];
        item.b_day   = s_tdata[27:23];
        item.b_month = s_tdata[31:28];
        item.b_year  = s_tdata[45:32];
        item.amount  = s_tdata[61:46];
    end

    cdau_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid),
        .item      (item),
        .ready     (core_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign s_tready  = core_ready;
    assign res_ready = !out_valid_reg || m_tready;

    // Output register: valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.b_after_a, out_reg.a_valid, out_reg.count,
                       out_reg.r_year, out_reg.r_month, out_reg.r_day};
    assign m_tuser  = out_reg.error;

endmodule

// ===== rtl/cdau_checker.sv =====
`include "calendar_date_arithmetic_unit_defines.svh"

module cdau_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // The unit works on one transaction at a time.
    `CDAU_ASSERT(a_accept_drops_ready, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "ready stayed high after an accepted transaction")

    // A stalled result holds still.
    `CDAU_ASSERT(a_hold_result, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // An error result never carries compare flags.
    `CDAU_ASSERT(a_error_clean, aclk, aresetn, m_tvalid && m_tuser[0] |-> !m_tdata[46] && !m_tdata[47], "error result carries compare flags")

    // A compare result carries no date, no count and no error.
    `CDAU_ASSERT(a_compare_clean, aclk, aresetn, m_tvalid && (m_tdata[46] || m_tdata[47]) |-> (m_tdata[45:0] == 46'd0) && !m_tuser[0], "compare result has stray fields")

    // Reset leaves the unit idle with no result pending.
    `CDAU_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid && s_tready, "unit not idle after reset")

endmodule

bind calendar_date_arithmetic_unit cdau_checker u_cdau_checker (.*);

// ===== tb/calendar_date_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps

module calendar_date_arithmetic_unit_test;
    import cdau_pkg::*;

    // Opcodes the block does not define; they must give an all-zero result.
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam longint COUNT_TOP    = 64'sd4194303;
    localparam longint COUNT_BOTTOM = -64'sd4194304;

    localparam int RANDOM_ITEMS = 75;
    localparam int HOLD_CYCLES  = 2000;
    localparam int HOLD_AFTER   = 40;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 4000000;

    typedef struct {
        cdau_item_t   item;
        bit           known;
        cdau_result_t res;
    } date_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [2:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    cdau_result_t pending_results[$];
    date_row_t    directed_rows[$];
    int           mismatch_cnt   = 0;
    int           results_seen   = 0;
    int           accepted_cnt   = 0;
    int           cycle_cnt      = 0;
    bit           hold_done      = 1'b0;
    int           op_seen[8];

    calendar_date_arithmetic_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock.
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Gregorian leap rule.
    function automatic bit is_leap(input int y);
        return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
    endfunction

    // Length of month m (1..12) in year y.
    function automatic int month_days(input int m, input int y);
        int len;
        case (m) inside
            2:             len = is_leap(y) ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    // Running day number; month codes above 12 count the whole year.
    function automatic longint day_index(input int d, input int m, input int y);
        longint total;
        longint n;
        int     top;
        total = 0;
        if (y >= 1) begin
            n = y - 1;
            total = 365 * n + n / 4 - n / 100 + n / 400;
        end
        top = (m > 13) ? 13 : m;
        for (int i = 1; i < top; i++) begin
            total += month_days(i, y);
        end
        return total + d;
    endfunction

    // True when the second date is strictly later than the first.
    function automatic bit is_later(input int d1, input int m1, input int y1,
                                    input int d2, input int m2, input int y2);
        if (y2 != y1) return y2 > y1;
        if (m2 != m1) return m2 > m1;
        return d2 > d1;
    endfunction

    // Expected result of one request.
    function automatic cdau_result_t compute_date_result(input cdau_item_t it);
        cdau_result_t res;
        int           ad, am, ay, bd, bm, by, amt;
        int           d, m, y, t, len;
        longint       diff;
        res = '0;
        ad  = int'(it.a_day);
        am  = int'(it.a_month);
        ay  = int'(it.a_year);
        bd  = int'(it.b_day);
        bm  = int'(it.b_month);
        by  = int'(it.b_year);
        amt = int'(it.amount);
        case (it.opcode) inside
            OP_ADD_DAYS, OP_ADD_MONTHS: begin
                if (am < 1 || am > 12) begin
                    res.error = 1'b1;
                end else if (it.opcode == OP_ADD_DAYS) begin
                    d = ad + amt;
                    m = am;
                    y = ay;
                    // Walk forward one month at a time.
                    while (d > month_days(m, y)) begin
                        d -= month_days(m, y);
                        m++;
                        if (m > 12) begin
                            m = 1;
                            y++;
                        end
                    end
                    res.r_day   = d[4:0];
                    res.r_month = m[3:0];
                    res.r_year  = y[13:0];
                end else begin
                    t   = am - 1 + amt;
                    m   = t % 12 + 1;
                    y   = ay + t / 12;
                    len = month_days(m, y);
                    d   = (ad > len) ? len : ad;
                    res.r_day   = d[4:0];
                    res.r_month = m[3:0];
                    res.r_year  = y[13:0];
                end
            end
            OP_DAY_DIFF: begin
                diff = day_index(bd, bm, by) - day_index(ad, am, ay);
                if (diff > COUNT_TOP) diff = COUNT_TOP;
                if (diff < COUNT_BOTTOM) diff = COUNT_BOTTOM;
                res.count = diff[22:0];
            end
            OP_MONTHS_BETWEEN: begin
                if (is_later(bd, bm, by, ad, am, ay)) begin
                    res.error = 1'b1;
                    res.count = '1;
                end else begin
                    diff = (longint'(by) - longint'(ay)) * 12 + (longint'(bm) - longint'(am));
                    if (bd < ad) diff--;
                    res.count = diff[22:0];
                end
            end
            OP_VALIDATE: begin
                res.a_valid = (ay > 1) && (am >= 1) && (am <= 12) && (ad >= 1)
                              && (ad <= month_days(am, ay));
                res.b_after_a = is_later(ad, am, ay, bd, bm, by);
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    function automatic cdau_result_t mk_res(input int d, input int m, input int y,
                                            input int cnt, input bit av, input bit ba,
                                            input bit err);
        cdau_result_t res;
        res.r_day     = d[4:0];
        res.r_month   = m[3:0];
        res.r_year    = y[13:0];
        res.count     = cnt[22:0];
        res.a_valid   = av;
        res.b_after_a = ba;
        res.error     = err;
        return res;
    endfunction

    task automatic add_row(input logic [2:0] op, input int ad, input int am, input int ay,
                           input int bd, input int bm, input int by, input int amt,
                           input bit known, input cdau_result_t res);
        date_row_t row;
        row.item.opcode  = op;
        row.item.a_day   = ad[4:0];
        row.item.a_month = am[3:0];
        row.item.a_year  = ay[13:0];
        row.item.b_day   = bd[4:0];
        row.item.b_month = bm[3:0];
        row.item.b_year  = by[13:0];
        row.item.amount  = amt[15:0];
        row.known        = known;
        row.res          = res;
        directed_rows.push_back(row);
    endtask

    // Idle length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(12, 80);
    endfunction

    // Random date: mostly a real calendar date, sometimes raw field noise.
    function automatic void rand_date(output logic [4:0] d, output logic [3:0] m,
                                      output logic [13:0] y);
        int yy, mm, len;
        if ($urandom_range(0, 99) < 85) begin
            mm = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0:       yy = $urandom_range(0, 4);
                1:       yy = $urandom_range(9990, 9999);
                2:       yy = $urandom_range(0, 99) * 100;
                3:       yy = $urandom_range(1, 2499) * 4;
                default: yy = $urandom_range(1, 9999);
            endcase
            len = month_days(mm, yy);
            d = ($urandom_range(0, 9) < 3) ? len[4:0] : 5'($urandom_range(1, len));
            m = mm[3:0];
            y = yy[13:0];
        end else begin
            d = 5'($urandom_range(0, 31));
            m = 4'($urandom_range(0, 15));
            y = 14'($urandom_range(0, 9999));
        end
    endfunction

    function automatic cdau_item_t rand_item();
        cdau_item_t it;
        int         r;
        r = $urandom_range(0, 99);
        it.opcode = (r < 97) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        rand_date(it.a_day, it.a_month, it.a_year);
        rand_date(it.b_day, it.b_month, it.b_year);
        // Keep the second date close to the first for many comparisons.
        r = $urandom_range(0, 9);
        if (r == 0) begin
            it.b_day   = it.a_day;
            it.b_month = it.a_month;
            it.b_year  = it.a_year;
        end else if (r < 3) begin
            it.b_month = it.a_month;
            it.b_year  = it.a_year;
        end else if (r < 5) begin
            it.b_year  = it.a_year;
        end
        // Large amounts are slow, so most stay small.
        r = $urandom_range(0, 99);
        if (r < 80) it.amount = 16'($urandom_range(0, 400));
        else if (r < 92) it.amount = 16'($urandom_range(0, 5000));
        else it.amount = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    // Offer one request and record its expected result once it is accepted.
    task automatic send_item(input cdau_item_t it, input bit known, input cdau_result_t typed);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.opcode;
        s_tdata  <= {2'b00, it.amount, it.b_year, it.b_month, it.b_day,
                     it.a_year, it.a_month, it.a_day};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(known ? typed : compute_date_result(it));
        op_seen[it.opcode]++;
        accepted_cnt++;
        @(negedge aclk);
    endtask

    // Timeout guard.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result checker: every transaction on the output is matched in order.
    always @(posedge aclk) begin
        cdau_result_t got;
        cdau_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            got.r_day     = m_tdata[4:0];
            got.r_month   = m_tdata[8:5];
            got.r_year    = m_tdata[22:9];
            got.count     = m_tdata[45:23];
            got.a_valid   = m_tdata[46];
            got.b_after_a = m_tdata[47];
            got.error     = m_tuser[0];
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("Unexpected result %0d: day %0d month %0d year %0d count %0d",
                             results_seen, got.r_day, got.r_month, got.r_year,
                             $signed(got.count));
            end else begin
                exp_res = pending_results.pop_front();
                if ((got.r_day !== exp_res.r_day) || (got.r_month !== exp_res.r_month) ||
                    (got.r_year !== exp_res.r_year) || (got.count !== exp_res.count) ||
                    (got.a_valid !== exp_res.a_valid) ||
                    (got.b_after_a !== exp_res.b_after_a) ||
                    (got.error !== exp_res.error)) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("Mismatch on result %0d", results_seen);
                        $display("  expected: day %0d month %0d year %0d count %0d valid %b after %b error %b",
                                 exp_res.r_day, exp_res.r_month, exp_res.r_year,
                                 $signed(exp_res.count), exp_res.a_valid,
                                 exp_res.b_after_a, exp_res.error);
                        $display("  actual:   day %0d month %0d year %0d count %0d valid %b after %b error %b",
                                 got.r_day, got.r_month, got.r_year, $signed(got.count),
                                 got.a_valid, got.b_after_a, got.error);
                    end
                end
            end
        end
    end

    // Receiver: random back-pressure plus one long hold while requests keep coming.
    initial begin
        int g;
        m_tready = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge aclk);
            g = gap_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(negedge aclk);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        cdau_item_t it;
        foreach (op_seen[i]) op_seen[i] = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Bad month in an add: error set, date left zero.
        add_row(OP_ADD_DAYS, 15, 0, 2020, 1, 1, 1, 10, 1, mk_res(0, 0, 0, 0, 0, 0, 1));
        add_row(OP_ADD_MONTHS, 15, 13, 2020, 1, 1, 1, 3, 1, mk_res(0, 0, 0, 0, 0, 0, 1));
        add_row(OP_ADD_DAYS, 31, 15, 9999, 31, 15, 9999, 65535, 1,
                mk_res(0, 0, 0, 0, 0, 0, 1));
        // Day zero is carried through an add.
        add_row(OP_ADD_DAYS, 0, 5, 2021, 0, 0, 0, 0, 1, mk_res(0, 5, 2021, 0, 0, 0, 0));
        add_row(OP_ADD_MONTHS, 0, 3, 2021, 0, 0, 0, 7, 1, mk_res(0, 10, 2021, 0, 0, 0, 0));
        // Roll over the last day of the largest year.
        add_row(OP_ADD_DAYS, 31, 12, 9999, 0, 0, 0, 1, 1, mk_res(1, 1, 10000, 0, 0, 0, 0));
        add_row(OP_ADD_DAYS, 1, 1, 0, 0, 0, 0, 65535, 0, '0);
        // Month add clamps to the end of February.
        add_row(OP_ADD_MONTHS, 31, 1, 2024, 0, 0, 0, 1, 1, mk_res(29, 2, 2024, 0, 0, 0, 0));
        add_row(OP_ADD_MONTHS, 31, 1, 2023, 0, 0, 0, 1, 1, mk_res(28, 2, 2023, 0, 0, 0, 0));
        add_row(OP_ADD_MONTHS, 31, 12, 9999, 0, 0, 0, 65535, 0, '0);
        // Day differences, including raw month codes and the widest span.
        add_row(OP_DAY_DIFF, 1, 1, 2000, 1, 3, 2000, 0, 1, mk_res(0, 0, 0, 60, 0, 0, 0));
        add_row(OP_DAY_DIFF, 0, 0, 0, 31, 15, 9999, 0, 0, '0);
        add_row(OP_DAY_DIFF, 31, 12, 9999, 1, 1, 1, 0, 0, '0);
        add_row(OP_DAY_DIFF, 5, 13, 2001, 5, 15, 2001, 0, 0, '0);
        // Month count: end before start, partial month, raw months, same date.
        add_row(OP_MONTHS_BETWEEN, 10, 6, 2020, 9, 6, 2020, 0, 1,
                mk_res(0, 0, 0, -1, 0, 0, 1));
        add_row(OP_MONTHS_BETWEEN, 15, 1, 2020, 14, 3, 2020, 0, 1,
                mk_res(0, 0, 0, 1, 0, 0, 0));
        add_row(OP_MONTHS_BETWEEN, 1, 14, 2020, 1, 2, 2021, 0, 0, '0);
        add_row(OP_MONTHS_BETWEEN, 7, 7, 7, 7, 7, 7, 0, 1, mk_res(0, 0, 0, 0, 0, 0, 0));
        // Validity and ordering.
        add_row(OP_VALIDATE, 29, 2, 2024, 1, 3, 2024, 0, 1, mk_res(0, 0, 0, 0, 1, 1, 0));
        add_row(OP_VALIDATE, 29, 2, 1900, 29, 2, 1900, 0, 1, mk_res(0, 0, 0, 0, 0, 0, 0));
        add_row(OP_VALIDATE, 1, 1, 1, 1, 1, 0, 0, 1, mk_res(0, 0, 0, 0, 0, 0, 0));
        add_row(OP_VALIDATE, 29, 2, 2000, 28, 2, 2000, 0, 1, mk_res(0, 0, 0, 0, 1, 0, 0));
        add_row(OP_VALIDATE, 0, 12, 9999, 31, 12, 9999, 0, 1, mk_res(0, 0, 0, 0, 0, 1, 0));
        // Undefined opcodes answer with zeros.
        add_row(OP_UNUSED_LO, 31, 15, 9999, 31, 15, 9999, 65535, 1,
                mk_res(0, 0, 0, 0, 0, 0, 0));
        add_row(OP_UNUSED_HI, 1, 1, 1, 2, 2, 2, 1, 1, mk_res(0, 0, 0, 0, 0, 0, 0));

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].res);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            it = rand_item();
            send_item(it, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Drain every outstanding result, then let the block settle.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results from %0d requests (%0d directed) in %0d cycles",
                 results_seen, accepted_cnt, directed_rows.size(), cycle_cnt);
        $display("Per opcode: add days %0d, add months %0d, diff %0d, months %0d, validate %0d, unused %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
